### hdl/ecc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecc_pkg: shared types, codes and tables of the epoch calendar converter
// Holds the transfer payload structures, the controller-to-datapath command
// and status structures, the datapath operation codes and the month tables.
// ----------------------------------------------------------------------------
package ecc_pkg;

    // Last representable instant: 2099-12-31 23:59:59.
    localparam logic [31:0] LAST_VALID_SECOND = 32'd3155759999;
    localparam logic [16:0] SECS_PER_DAY      = 17'd86400;
    localparam logic [16:0] SECS_PER_MIN      = 17'd60;
    localparam logic [16:0] DAYS_PER_WEEK     = 17'd7;
    localparam logic [15:0] QUAD_YEAR_DAYS    = 16'd1461;
    // Day zero (2000-01-01) was a Saturday.
    localparam logic [15:0] WEEKDAY_OFFSET    = 16'd6;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_IDLE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_CHECK    = 4'd2;
    localparam logic [3:0] OP_DIV_LOAD = 4'd3;
    localparam logic [3:0] OP_DIV_TAKE = 4'd4;
    localparam logic [3:0] OP_MUL_H    = 4'd5;
    localparam logic [3:0] OP_MUL_M    = 4'd6;
    localparam logic [3:0] OP_MUL_S    = 4'd7;
    localparam logic [3:0] OP_YEAR     = 4'd8;
    localparam logic [3:0] OP_MONTH    = 4'd9;
    localparam logic [3:0] OP_EMIT     = 4'd10;

    // Which constant division the shared divider performs.
    localparam logic [1:0] DSEL_DAY = 2'd0;
    localparam logic [1:0] DSEL_SEC = 2'd1;
    localparam logic [1:0] DSEL_MIN = 2'd2;
    localparam logic [1:0] DSEL_WD  = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [31:0] in_total_seconds;
        logic [6:0]  in_year_offset;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [4:0]  in_hour;
        logic [5:0]  in_minute;
        logic [5:0]  in_second;
    } t_ecc_in;

    typedef struct packed {
        logic [31:0] out_total_seconds;
        logic [6:0]  out_year_offset;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic [2:0]  weekday;
        logic        bad_input;
    } t_ecc_out;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] div_sel;
    } t_ecc_cmd;

    typedef struct packed {
        logic mode;
        logic bad;
        logic div_done;
        logic year_done;
        logic month_done;
    } t_ecc_sts;

    function automatic logic [4:0] f_month_len(input logic [6:0] yoff,
                                               input logic [3:0] mon);
        logic [4:0] len;
        case (mon)
            4'd2:    len = (yoff[1:0] == 2'd0) ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the months before the given one, in a common year.
    function automatic logic [8:0] f_days_before(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

### hdl/ecc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecc_div: constant divider of the epoch calendar converter
// Divides by 86400, 60 or 7 with reciprocal multiplication. The quotient is
// registered after loading, and the remainder after it from that quotient.
// ----------------------------------------------------------------------------
module ecc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire logic [1:0]  i_sel,
    input  wire logic [31:0] i_num,
    output logic             o_done,
    output logic [15:0]      o_quo,
    output logic [16:0]      o_rem
);
    import ecc_pkg::*;

    // Reciprocals rounded up. 86400 is 128 times 675 and 60 is 4 times 15, so
    // the low bits are shifted off first. Each product then gives the exact
    // quotient over the whole range of dividends that the datapath presents.
    localparam logic [25:0] RECIP_675 = 26'd50903317;
    localparam logic [15:0] RECIP_15  = 16'd34953;
    localparam logic [15:0] RECIP_7   = 16'd37450;

    logic [31:0] r_num;
    logic [1:0]  r_sel;
    logic [15:0] r_quo;
    logic [16:0] r_rem;
    logic [1:0]  r_cnt;
    logic [50:0] prod_day;
    logic [30:0] prod_min;
    logic [31:0] prod_wd;
    logic [15:0] quo;
    logic [16:0] den;
    logic [31:0] back;
    logic [31:0] rem_full;

    always_comb begin
        prod_day = 51'(r_num[31:7]) * 51'(RECIP_675);
        prod_min = 31'(r_num[16:2]) * 31'(RECIP_15);
        prod_wd  = 32'(r_num[15:0]) * 32'(RECIP_7);
        case (r_sel)
            DSEL_DAY: begin
                quo = prod_day[50:35];
                den = SECS_PER_DAY;
            end
            DSEL_SEC, DSEL_MIN: begin
                quo = 16'(prod_min[30:19]);
                den = SECS_PER_MIN;
            end
            default: begin
                quo = 16'(prod_wd[31:18]);
                den = DAYS_PER_WEEK;
            end
        endcase
        back     = 32'(r_quo) * 32'(den);
        rem_full = r_num - back;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= 2'd2;
        end else if (r_cnt != 2'd0) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num <= i_num;
            r_sel <= i_sel;
        end else if (r_cnt == 2'd2) begin
            r_quo <= quo;
        end else if (r_cnt == 2'd1) begin
            r_rem <= rem_full[16:0];
        end
    end

    assign o_done = (r_cnt == 2'd0);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

### hdl/ecc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecc_dp: datapath of the epoch calendar converter
// Holds the working registers, the field checks, the year and month walks,
// the constant multiplications and the shared divider.
// ----------------------------------------------------------------------------
module ecc_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ecc_pkg::t_ecc_in i_item,
    input  wire ecc_pkg::t_ecc_cmd i_cmd,
    output ecc_pkg::t_ecc_sts     o_sts,
    output ecc_pkg::t_ecc_out     o_result
);
    import ecc_pkg::*;

    t_ecc_in     r_in;
    t_ecc_out    r_out;
    logic        r_bad;
    logic [15:0] r_days;
    logic [15:0] r_rem_days;
    logic [31:0] r_acc;
    logic [16:0] r_sod;
    logic [10:0] r_mod;
    logic [6:0]  r_yoff;
    logic [3:0]  r_mon;
    logic [4:0]  r_day;
    logic [4:0]  r_hr;
    logic [5:0]  r_mi;
    logic [5:0]  r_se;
    logic [2:0]  r_wd;

    logic        bad_now;
    logic [15:0] date_days;
    logic [15:0] year_len;
    logic [4:0]  walk_month_len;
    logic        year_done;
    logic        month_done;
    logic [31:0] div_num;
    logic        div_load;
    logic        div_done;
    logic [15:0] div_quo;
    logic [16:0] div_rem;
    t_ecc_out    bad_result;

    // Range checks on the captured item.
    always_comb begin
        if (!r_in.mode) begin
            bad_now = (r_in.in_total_seconds > LAST_VALID_SECOND);
        end else begin
            bad_now = (r_in.in_year_offset > 7'd99) || (r_in.in_month < 4'd1) ||
                      (r_in.in_month > 4'd12) || (r_in.in_day < 5'd1) ||
                      (r_in.in_day > f_month_len(r_in.in_year_offset, r_in.in_month)) ||
                      (r_in.in_hour > 5'd23) || (r_in.in_minute > 6'd59) ||
                      (r_in.in_second > 6'd59);
        end
    end

    // Day number of a date, counted from 2000-01-01 as day zero.
    always_comb begin
        date_days = 16'(r_in.in_day) + 16'(f_days_before(r_in.in_month)) +
                    16'(((r_in.in_month > 4'd2) && (r_in.in_year_offset[1:0] == 2'd0))
                        ? 1'b1 : 1'b0) +
                    16'(16'(r_in.in_year_offset) * 16'd365) +
                    16'((8'(r_in.in_year_offset) + 8'd3) >> 2) - 16'd1;
    end

    always_comb begin
        year_len       = (r_yoff[1:0] == 2'd0) ? 16'd366 : 16'd365;
        walk_month_len = f_month_len(r_yoff, r_mon);
        year_done      = (r_rem_days < QUAD_YEAR_DAYS) && (r_rem_days < year_len);
        month_done     = (r_mon == 4'd12) || (r_rem_days < 16'(walk_month_len));
    end

    always_comb begin
        div_load = (i_cmd.op == OP_DIV_LOAD);
        case (i_cmd.div_sel)
            DSEL_DAY: div_num = r_in.in_total_seconds;
            DSEL_SEC: div_num = 32'(r_sod);
            DSEL_MIN: div_num = 32'(r_mod);
            default:  div_num = 32'(16'(r_days + WEEKDAY_OFFSET));
        endcase
    end

    // Result of a request that could not be converted.
    always_comb begin
        bad_result           = '0;
        bad_result.bad_input = 1'b1;
    end

    ecc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (div_load),
        .i_sel   (i_cmd.div_sel),
        .i_num   (div_num),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_in <= i_item;
            end
            OP_CHECK: begin
                r_bad <= bad_now;
                if (!r_in.mode) begin
                    r_acc  <= r_in.in_total_seconds;
                    r_yoff <= '0;
                    r_mon  <= 4'd1;
                end else begin
                    r_days <= date_days;
                    r_yoff <= r_in.in_year_offset;
                    r_mon  <= r_in.in_month;
                    r_day  <= r_in.in_day;
                    r_hr   <= r_in.in_hour;
                    r_mi   <= r_in.in_minute;
                    r_se   <= r_in.in_second;
                end
            end
            OP_DIV_TAKE: begin
                case (i_cmd.div_sel)
                    DSEL_DAY: begin
                        r_days     <= div_quo;
                        r_rem_days <= div_quo;
                        r_sod      <= div_rem;
                    end
                    DSEL_SEC: begin
                        r_mod <= div_quo[10:0];
                        r_se  <= div_rem[5:0];
                    end
                    DSEL_MIN: begin
                        r_hr <= div_quo[4:0];
                        r_mi <= div_rem[5:0];
                    end
                    default: begin
                        r_wd <= div_rem[2:0];
                    end
                endcase
            end
            OP_MUL_H: begin
                r_acc <= 32'(r_days) * 32'd24 + 32'(r_hr);
            end
            OP_MUL_M: begin
                r_acc <= 32'(r_acc * 32'd60) + 32'(r_mi);
            end
            OP_MUL_S: begin
                r_acc <= 32'(r_acc * 32'd60) + 32'(r_se);
            end
            OP_YEAR: begin
                // Whole four-year blocks first, then single years.
                if (r_rem_days >= QUAD_YEAR_DAYS) begin
                    r_rem_days <= r_rem_days - QUAD_YEAR_DAYS;
                    r_yoff     <= r_yoff + 7'd4;
                end else if (r_rem_days >= year_len) begin
                    r_rem_days <= r_rem_days - year_len;
                    r_yoff     <= r_yoff + 7'd1;
                end
            end
            OP_MONTH: begin
                if (month_done) begin
                    r_day <= 5'(r_rem_days + 16'd1);
                end else begin
                    r_rem_days <= r_rem_days - 16'(walk_month_len);
                    r_mon      <= r_mon + 4'd1;
                end
            end
            OP_EMIT: begin
                if (r_bad) begin
                    r_out <= bad_result;
                end else begin
                    r_out.out_total_seconds <= r_acc;
                    r_out.out_year_offset   <= r_yoff;
                    r_out.out_month         <= r_mon;
                    r_out.out_day           <= r_day;
                    r_out.out_hour          <= r_hr;
                    r_out.out_minute        <= r_mi;
                    r_out.out_second        <= r_se;
                    r_out.weekday           <= r_wd;
                    r_out.bad_input         <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.mode       = r_in.mode;
        o_sts.bad        = bad_now;
        o_sts.div_done   = div_done;
        o_sts.year_done  = year_done;
        o_sts.month_done = month_done;
    end

    assign o_result = r_out;

endmodule
`default_nettype wire

### hdl/ecc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecc_ctrl: sequencing state machine of the epoch calendar converter
// Steps the datapath through checking, division, multiplication and the
// calendar walks, and raises the result strobe.
// ----------------------------------------------------------------------------
module ecc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire ecc_pkg::t_ecc_sts i_sts,
    output ecc_pkg::t_ecc_cmd      o_cmd,
    output logic                   o_busy,
    output logic                   o_done
);
    import ecc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_DVL   = 4'd2;
    localparam logic [3:0] S_DVR   = 4'd3;
    localparam logic [3:0] S_MULH  = 4'd4;
    localparam logic [3:0] S_MULM  = 4'd5;
    localparam logic [3:0] S_MULS  = 4'd6;
    localparam logic [3:0] S_YEAR  = 4'd7;
    localparam logic [3:0] S_MONTH = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;
    logic       r_done, n_done;

    always_comb begin
        n_state       = r_state;
        n_sel         = r_sel;
        n_done        = 1'b0;
        o_cmd.op      = OP_IDLE;
        o_cmd.div_sel = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.op = OP_CHECK;
                if (i_sts.bad) begin
                    n_state = S_EMIT;
                end else if (!i_sts.mode) begin
                    n_sel   = DSEL_DAY;
                    n_state = S_DVL;
                end else begin
                    n_state = S_MULH;
                end
            end
            S_DVL: begin
                o_cmd.op = OP_DIV_LOAD;
                n_state  = S_DVR;
            end
            S_DVR: begin
                if (i_sts.div_done) begin
                    o_cmd.op = OP_DIV_TAKE;
                    case (r_sel)
                        DSEL_DAY: begin
                            n_sel   = DSEL_SEC;
                            n_state = S_DVL;
                        end
                        DSEL_SEC: begin
                            n_sel   = DSEL_MIN;
                            n_state = S_DVL;
                        end
                        DSEL_MIN: begin
                            n_sel   = DSEL_WD;
                            n_state = S_DVL;
                        end
                        default: begin
                            n_state = i_sts.mode ? S_EMIT : S_YEAR;
                        end
                    endcase
                end
            end
            S_MULH: begin
                o_cmd.op = OP_MUL_H;
                n_state  = S_MULM;
            end
            S_MULM: begin
                o_cmd.op = OP_MUL_M;
                n_state  = S_MULS;
            end
            S_MULS: begin
                o_cmd.op = OP_MUL_S;
                n_sel    = DSEL_WD;
                n_state  = S_DVL;
            end
            S_YEAR: begin
                o_cmd.op = OP_YEAR;
                if (i_sts.year_done) begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                o_cmd.op = OP_MONTH;
                if (i_sts.month_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.op = OP_EMIT;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= DSEL_DAY;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule
`default_nettype wire

### hdl/epoch_calendar_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_calendar_converter: seconds since 2000 to and from calendar fields
// Converts a seconds count from 2000-01-01 00:00:00 into calendar fields and
// weekday, or combines those fields into a seconds count, for 2000 to 2099.
// ----------------------------------------------------------------------------
// A request is transferred on a rising edge where start is high and busy is
// low; i_item carries the mode and the fields. The result stays on o_result
// until the next one, marked by o_done for exactly one cycle. The receiver
// cannot stall it, and a new request may be transferred in that same cycle.
// Splitting seconds runs a check, four constant divisions, the year walk
// (four-year blocks, then up to three single years), the month walk and the
// output step, which registers the result and the strobe together. Combining
// fields runs the check, three multiplies, the weekday division and the
// output step. A rejected request goes from the check to the output step.
// One request is handled at a time: a new one is taken only while busy is low.
// Reset: a synchronous low i_rst_n returns the sequencer to idle and clears
// the strobe.
// ----------------------------------------------------------------------------
module epoch_calendar_converter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire ecc_pkg::t_ecc_in  i_item,
    output logic                   busy,
    output logic                   o_done,
    output ecc_pkg::t_ecc_out      o_result
);
    import ecc_pkg::*;

    t_ecc_cmd cmd;
    t_ecc_sts sts;

    // The controller sequences the work; it sees only start and the status bundle.
    ecc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // The datapath holds the request, the working registers and the
    // result register, which is loaded in the same cycle the strobe is set.
    ecc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

### test/tb_epoch_calendar_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_calendar_converter: self-checking bench for the calendar converter
// Sends split and combine requests through the start/busy handshake. Each
// request is scored against a local prediction of the calendar arithmetic, and
// each o_done result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_epoch_calendar_converter;
    import ecc_pkg::*;

    // Direction of a conversion, as carried in the mode bit of a request.
    localparam logic MODE_SPLIT = 1'b0;
    localparam logic MODE_JOIN  = 1'b1;

    // The limit exceeds the worst conversion plus the longest sender gap, so
    // running into it can only mean a hung block.
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int PHASE_ITEMS   = 475;
    localparam int REPORT_LIMIT  = 10;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_ecc_in  i_item  = '0;
    logic     busy;
    logic     o_done;
    t_ecc_out o_result;

    // Requests waiting to be offered, and predicted results waiting for o_done.
    t_ecc_in  pending_requests [$];
    t_ecc_out expected_dates   [$];

    int idle_pct      = 0;
    int queued_cnt    = 0;
    int accepted_cnt  = 0;
    int results_cnt   = 0;
    int split_cnt     = 0;
    int join_cnt      = 0;
    int flagged_cnt   = 0;
    int mismatch_cnt  = 0;
    int quiet_cycles  = 0;
    logic took_item   = 1'b0;

    epoch_calendar_converter u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Calendar arithmetic
    // ------------------------------------------------------------------------

    // Length of a month; February gains a day in a leap year. Every fourth
    // year from 2000 onwards is a leap year, with no century exception.
    function automatic int unsigned month_days(input logic leap, input int unsigned mon);
        case (mon)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Predicts the full result of one request. The whole arithmetic is done in
    // 32-bit unsigned integers so that wrap-around matches the hardware.
    function automatic t_ecc_out calc_calendar(input t_ecc_in req);
        t_ecc_out    res;
        int unsigned t, days, rem, ylen, y, mon, dd, hh, mm, ss, i;
        logic        bad;
        res = '0;
        bad = 1'b0;
        if (req.mode == MODE_SPLIT) begin
            t = req.in_total_seconds;
            if (t > LAST_VALID_SECOND) begin
                bad = 1'b1;
            end else begin
                res.out_total_seconds = t;
                res.out_second = 6'(t % 60);
                t = t / 60;
                res.out_minute = 6'(t % 60);
                t = t / 60;
                res.out_hour   = 5'(t % 24);
                days = t / 24;
                res.weekday    = 3'((days + 6) % 7);
                // Walk whole years, then whole months, off the day count.
                rem = days;
                for (y = 0; y < 99; y++) begin
                    ylen = (y % 4 == 0) ? 366 : 365;
                    if (rem < ylen) break;
                    rem -= ylen;
                end
                for (mon = 1; mon < 12; mon++) begin
                    if (rem < month_days(y % 4 == 0, mon)) break;
                    rem -= month_days(y % 4 == 0, mon);
                end
                res.out_year_offset = 7'(y);
                res.out_month       = 4'(mon);
                res.out_day         = 5'(rem + 1);
            end
        end else begin
            y   = 32'(req.in_year_offset);
            mon = 32'(req.in_month);
            dd  = 32'(req.in_day);
            hh  = 32'(req.in_hour);
            mm  = 32'(req.in_minute);
            ss  = 32'(req.in_second);
            if (y > 99 || mon < 1 || mon > 12 || dd < 1 ||
                dd > month_days(y % 4 == 0, mon) || hh > 23 || mm > 59 || ss > 59) begin
                bad = 1'b1;
            end else begin
                days = dd;
                for (i = 1; i < mon; i++)
                    days += month_days(1'b0, i);
                if (mon > 2 && y % 4 == 0)
                    days++;
                // Day zero is 2000-01-01, hence the final decrement.
                days = days + 365 * y + (y + 3) / 4 - 1;
                res.out_total_seconds = ((days * 24 + hh) * 60 + mm) * 60 + ss;
                res.out_year_offset   = 7'(y);
                res.out_month         = 4'(mon);
                res.out_day           = 5'(dd);
                res.out_hour          = 5'(hh);
                res.out_minute        = 6'(mm);
                res.out_second        = 6'(ss);
                res.weekday           = 3'((days + 6) % 7);
            end
        end
        // An invalid request yields a result that is all zero but for the flag.
        if (bad) begin
            res = '0;
            res.bad_input = 1'b1;
        end
        return res;
    endfunction

    function automatic string date_str(input t_ecc_out r);
        return $sformatf("secs=%0d y=%0d m=%0d d=%0d %0d:%0d:%0d wd=%0d bad=%0d",
                         r.out_total_seconds, r.out_year_offset, r.out_month,
                         r.out_day, r.out_hour, r.out_minute, r.out_second,
                         r.weekday, r.bad_input);
    endfunction

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------

    // The fields that a mode ignores are filled at random so that every input
    // bit toggles, and so that the block is seen to ignore them.
    function automatic t_ecc_in split_req(input logic [31:0] secs);
        t_ecc_in r;
        r = t_ecc_in'({2'($urandom), $urandom, $urandom});
        r.mode             = MODE_SPLIT;
        r.in_total_seconds = secs;
        return r;
    endfunction

    function automatic t_ecc_in join_req(input int unsigned y, input int unsigned mon,
                                         input int unsigned dd, input int unsigned hh,
                                         input int unsigned mm, input int unsigned ss);
        t_ecc_in r;
        r = t_ecc_in'({2'($urandom), $urandom, $urandom});
        r.mode           = MODE_JOIN;
        r.in_year_offset = 7'(y);
        r.in_month       = 4'(mon);
        r.in_day         = 5'(dd);
        r.in_hour        = 5'(hh);
        r.in_minute      = 6'(mm);
        r.in_second      = 6'(ss);
        return r;
    endfunction

    // Random traffic: mostly legal dates and counts, with a share of counts
    // just either side of a year or month start, where the walks are most
    // likely to slip, and a share of out-of-range noise.
    function automatic t_ecc_in rand_request();
        int unsigned pick, y, mon;
        logic [31:0] base;
        pick = $urandom_range(99, 0);
        y    = $urandom_range(99, 0);
        mon  = $urandom_range(12, 1);
        if (pick < 35) begin
            return split_req($urandom_range(LAST_VALID_SECOND, 0));
        end else if (pick < 50) begin
            base = calc_calendar(join_req(y, mon, 1, 0, 0, 0)).out_total_seconds;
            return split_req(base + $urandom_range(4, 0) - 2);
        end else if (pick < 56) begin
            return split_req($urandom_range(32'hFFFF_FFFF, LAST_VALID_SECOND + 1));
        end else if (pick < 88) begin
            return join_req(y, mon, $urandom_range(month_days(y % 4 == 0, mon), 1),
                            $urandom_range(23, 0), $urandom_range(59, 0),
                            $urandom_range(59, 0));
        end else begin
            return join_req($urandom_range(127, 0), $urandom_range(15, 0),
                            $urandom_range(31, 0), $urandom_range(31, 0),
                            $urandom_range(63, 0), $urandom_range(63, 0));
        end
    endfunction

    task automatic queue_request(input t_ecc_in r);
        pending_requests.push_back(r);
        queued_cnt++;
    endtask

    // Holds the stimulus back until every queued request has been transferred
    // and every predicted result has come back. Sampling at the falling edge
    // keeps clear of the updates that the monitor makes at the rising edge.
    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (accepted_cnt != queued_cnt || expected_dates.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers requests at the falling edge. Once start is raised, the
    // request is held until a transfer has happened; only then is the next
    // one taken from the queue, or start dropped for an idle cycle.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took_item) begin
            if (pending_requests.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
                start  <= 1'b1;
                i_item <= pending_requests.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and scoreboard: samples the handshake at the rising edge. A
    // result is scored before a request of the same cycle is predicted, since
    // the block may take a new request in the very cycle that o_done is high.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_ecc_out want;
        t_ecc_out guess;
        if (!i_rst_n) begin
            took_item    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            took_item <= start && !busy;

            if (o_done) begin
                results_cnt++;
                if (expected_dates.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display("%0t: result with no request outstanding: %s",
                                 $realtime, date_str(o_result));
                end else begin
                    want = expected_dates.pop_front();
                    if (o_result !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("    expected %s", date_str(want));
                            $display("    actual   %s", date_str(o_result));
                        end
                    end
                end
            end

            if (start && !busy) begin
                guess = calc_calendar(i_item);
                expected_dates.push_back(guess);
                accepted_cnt++;
                if (i_item.mode == MODE_SPLIT) split_cnt++;
                else join_cnt++;
                if (guess.bad_input) flagged_cnt++;
            end

            // Watchdog: any transfer in either direction counts as progress.
            if (o_done || (start && !busy)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : sequencer
        int idle_plan [4];
        int p, n;
        idle_plan = '{0, 51, 8, 0};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests. Splitting: the epoch itself, the last second of
        // the first day and the first of the second, the leap day of 2000
        // and the day after it, the turn of 2000-12-30 into 2000-12-31, the
        // start of the second four-year block, the last valid second, the first
        // count past it and the largest count.
        queue_request(split_req(32'd0));
        queue_request(split_req(32'd86399));
        queue_request(split_req(32'd86400));
        queue_request(split_req(32'd5097600));
        queue_request(split_req(32'd5184000));
        queue_request(split_req(32'd31535999));
        queue_request(split_req(32'd31536000));
        queue_request(split_req(32'd126230400));
        queue_request(split_req(LAST_VALID_SECOND));
        queue_request(split_req(LAST_VALID_SECOND + 32'd1));
        queue_request(split_req(32'hFFFF_FFFF));
        // Combining: the first and the last instant of the range, leap days in
        // a leap year and in a common year, and each field just out of range.
        queue_request(join_req(0, 1, 1, 0, 0, 0));
        queue_request(join_req(99, 12, 31, 23, 59, 59));
        queue_request(join_req(0, 2, 29, 12, 30, 30));
        queue_request(join_req(96, 2, 29, 6, 7, 8));
        queue_request(join_req(1, 2, 29, 0, 0, 0));
        queue_request(join_req(100, 1, 1, 0, 0, 0));
        queue_request(join_req(127, 15, 31, 31, 63, 63));
        queue_request(join_req(5, 0, 1, 0, 0, 0));
        queue_request(join_req(5, 13, 1, 0, 0, 0));
        queue_request(join_req(5, 4, 31, 0, 0, 0));
        queue_request(join_req(5, 6, 0, 0, 0, 0));
        queue_request(join_req(5, 3, 3, 24, 0, 0));
        queue_request(join_req(5, 3, 3, 0, 60, 0));
        queue_request(join_req(5, 3, 3, 0, 0, 60));
        wait_until_drained();

        // Random phases, each at the idle rate that idle_plan gives it. Every phase
        // ends with the sender paused until all of its results have come back.
        for (p = 0; p < 4; p++) begin
            @(posedge i_clk);
            idle_pct = idle_plan[p];
            for (n = 0; n < PHASE_ITEMS; n++)
                queue_request(rand_request());
            wait_until_drained();
        end

        // Allow for a late or spurious result before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d conversions (%0d split, %0d combine, %0d out of range) at",
                 accepted_cnt, split_cnt, join_cnt, flagged_cnt);
        $display("sender idle rates of 0, 51 and 8 percent; %0d results scored, %0d wrong.",
                 results_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && expected_dates.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
